>>> hw/rtl/sttok_pkg.sv
// Shared constants for the source text tokenizer: default widths, token kind codes,
// character codes and the keyword table.
// No dependencies.
package sttok_pkg;

  localparam int unsigned POS_BITS_DEFAULT      = 16;
  localparam int unsigned VALUE_BITS_DEFAULT    = 31;
  localparam int unsigned KEYWORD_BYTES_DEFAULT = 6;

  localparam int unsigned KIND_BITS = 6;

  localparam logic [KIND_BITS-1:0] K_END        = 6'd0;
  localparam logic [KIND_BITS-1:0] K_IF         = 6'd1;
  localparam logic [KIND_BITS-1:0] K_ELSE       = 6'd2;
  localparam logic [KIND_BITS-1:0] K_WHILE      = 6'd3;
  localparam logic [KIND_BITS-1:0] K_FOR        = 6'd4;
  localparam logic [KIND_BITS-1:0] K_RETURN     = 6'd5;
  localparam logic [KIND_BITS-1:0] K_FUNC       = 6'd6;
  localparam logic [KIND_BITS-1:0] K_ADD_ASSIGN = 6'd7;
  localparam logic [KIND_BITS-1:0] K_ADD        = 6'd8;
  localparam logic [KIND_BITS-1:0] K_SUB_ASSIGN = 6'd9;
  localparam logic [KIND_BITS-1:0] K_SUB        = 6'd10;
  localparam logic [KIND_BITS-1:0] K_MUL_ASSIGN = 6'd11;
  localparam logic [KIND_BITS-1:0] K_MUL        = 6'd12;
  localparam logic [KIND_BITS-1:0] K_DIV_ASSIGN = 6'd13;
  localparam logic [KIND_BITS-1:0] K_DIV        = 6'd14;
  localparam logic [KIND_BITS-1:0] K_MOD_ASSIGN = 6'd15;
  localparam logic [KIND_BITS-1:0] K_LPAREN     = 6'd16;
  localparam logic [KIND_BITS-1:0] K_RPAREN     = 6'd17;
  localparam logic [KIND_BITS-1:0] K_LBRACKET   = 6'd18;
  localparam logic [KIND_BITS-1:0] K_RBRACKET   = 6'd19;
  localparam logic [KIND_BITS-1:0] K_LBRACE     = 6'd20;
  localparam logic [KIND_BITS-1:0] K_RBRACE     = 6'd21;
  localparam logic [KIND_BITS-1:0] K_LOR        = 6'd22;
  localparam logic [KIND_BITS-1:0] K_BOR        = 6'd23;
  localparam logic [KIND_BITS-1:0] K_GE         = 6'd24;
  localparam logic [KIND_BITS-1:0] K_GT         = 6'd25;
  localparam logic [KIND_BITS-1:0] K_LE         = 6'd26;
  localparam logic [KIND_BITS-1:0] K_LT         = 6'd27;
  localparam logic [KIND_BITS-1:0] K_EQ         = 6'd28;
  localparam logic [KIND_BITS-1:0] K_ASSIGN     = 6'd29;
  localparam logic [KIND_BITS-1:0] K_NE         = 6'd30;
  localparam logic [KIND_BITS-1:0] K_NOT        = 6'd31;
  localparam logic [KIND_BITS-1:0] K_BNOT       = 6'd32;
  localparam logic [KIND_BITS-1:0] K_LAND       = 6'd33;
  localparam logic [KIND_BITS-1:0] K_BAND       = 6'd34;
  localparam logic [KIND_BITS-1:0] K_SEMI       = 6'd35;
  localparam logic [KIND_BITS-1:0] K_COMMA      = 6'd36;
  localparam logic [KIND_BITS-1:0] K_IDENT      = 6'd37;
  localparam logic [KIND_BITS-1:0] K_INT        = 6'd38;
  localparam logic [KIND_BITS-1:0] K_DEC        = 6'd39;
  localparam logic [KIND_BITS-1:0] K_ERR        = 6'd40;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam int unsigned KW_COUNT     = 6;
  localparam int unsigned KW_TEXT_BITS = 48;

  // Keyword text with the first byte in the lowest byte lane, zero padded.
  localparam logic [KW_TEXT_BITS-1:0] KW_TEXT [KW_COUNT] = '{
    48'("fi"), 48'("esle"), 48'("elihw"), 48'("rof"), 48'("nruter"), 48'("cnuf")
  };
  localparam int unsigned KW_LEN [KW_COUNT] = '{2, 4, 5, 3, 6, 4};

  // Kind of an operator that may take a second byte, or K_ERR for any other byte.
  function automatic logic [KIND_BITS-1:0] op_single(input logic [7:0] c);
    logic [KIND_BITS-1:0] k;
    case (c)
      "+":     k = K_ADD;
      "-":     k = K_SUB;
      "*":     k = K_MUL;
      "/":     k = K_DIV;
      "|":     k = K_BOR;
      ">":     k = K_GT;
      "<":     k = K_LT;
      "=":     k = K_ASSIGN;
      "!":     k = K_NOT;
      "&":     k = K_BAND;
      default: k = K_ERR;
    endcase
    return k;
  endfunction

  // Second byte that turns a pending operator into its two-byte form.
  function automatic logic [7:0] op_second(input logic [7:0] c);
    return (c == "|" || c == "&") ? c : 8'("=");
  endfunction

endpackage

>>> hw/rtl/source_text_tokenizer.sv
// Top level of the source text tokenizer: byte scanner state and a four-entry token queue.
// Depends on sttok_pkg for kind codes, character codes and the keyword table.
//
// It takes one source byte per cycle unless stalled and returns tokens in source order.
// A token is known only when the byte after it arrives, so one byte may give two tokens (the
// finished one and a single-byte token or error); byte 0 flushes any open token and adds an end
// token, then scanning restarts. All scanning for a byte happens in the cycle it is accepted,
// and its tokens can be taken from the next cycle on, one per cycle unless out_stall is high,
// from a four-entry queue. The input stalls only while fewer than two queue entries are free,
// so with the output taking a token every cycle the sustained rate is one byte per cycle;
// bursts of two-token bytes are limited by the one-token-per-cycle output. After an unexpected
// byte the error token is sent and all bytes up to the next byte 0 are consumed silently.
module source_text_tokenizer
  import sttok_pkg::*;
#(
  parameter int unsigned POS_BITS      = POS_BITS_DEFAULT,
  parameter int unsigned VALUE_BITS    = VALUE_BITS_DEFAULT,
  parameter int unsigned KEYWORD_BYTES = KEYWORD_BYTES_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            ch,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [KIND_BITS-1:0]  kind,
  output logic [POS_BITS-1:0]   start_pos,
  output logic [POS_BITS-1:0]   line,
  output logic [POS_BITS-1:0]   col,
  output logic [POS_BITS-1:0]   length,
  output logic [VALUE_BITS-1:0] value,
  output logic                  last_of_run
);

  localparam int unsigned KW_BITS    = 8 * KEYWORD_BYTES;
  localparam int unsigned PROD_BITS  = VALUE_BITS + 4;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_BITS   = FIFO_AW + 1;

  typedef enum logic [2:0] {
    M_IDLE, M_OP, M_IDENT, M_INT, M_DEC, M_COMMENT, M_HALT
  } mode_t;

  typedef struct packed {
    logic [KIND_BITS-1:0]  kind;
    logic [POS_BITS-1:0]   pos;
    logic [POS_BITS-1:0]   line;
    logic [POS_BITS-1:0]   col;
    logic [POS_BITS-1:0]   len;
    logic [VALUE_BITS-1:0] value;
    logic                  last;
  } tok_t;

  mode_t                 mode, mode_next;
  logic [7:0]            pending_char, pending_char_next;
  logic [POS_BITS-1:0]   line_count, line_count_next;
  logic [POS_BITS-1:0]   column_count, column_count_next;
  logic [POS_BITS-1:0]   byte_position, byte_position_next;
  logic [POS_BITS-1:0]   tok_pos, tok_pos_next;
  logic [POS_BITS-1:0]   tok_line, tok_line_next;
  logic [POS_BITS-1:0]   tok_col, tok_col_next;
  logic [POS_BITS-1:0]   tok_len, tok_len_next;
  logic [VALUE_BITS-1:0] value_acc, value_acc_next;
  logic [KW_BITS-1:0]    kw_prefix, kw_prefix_next;

  tok_t                  fifo [FIFO_DEPTH];
  logic [FIFO_AW-1:0]    rd_ptr, wr_ptr;
  logic [CNT_BITS-1:0]   count;

  logic                  accept, pop;
  logic [POS_BITS-1:0]   cur_col, tok_len_inc;
  logic [KIND_BITS-1:0]  ident_kind, pend_single;
  logic [PROD_BITS-1:0]  acc_ext, acc_prod;
  logic [VALUE_BITS-1:0] acc_step;
  logic                  p_valid, n_valid, fresh;
  tok_t                  p_tok, n_tok, r0, r1;
  logic [1:0]            n_push;

  assign accept = in_valid && !in_stall;
  assign pop    = out_valid && !out_stall;

  assign cur_col     = (column_count == '1) ? column_count : column_count + POS_BITS'(1);
  assign tok_len_inc = (tok_len == '1) ? tok_len : tok_len + POS_BITS'(1);
  assign pend_single = op_single(pending_char);

  assign acc_ext  = PROD_BITS'(value_acc);
  assign acc_prod = (acc_ext << 3) + (acc_ext << 1) + PROD_BITS'(ch[3:0]);
  assign acc_step = (acc_prod > PROD_BITS'({VALUE_BITS{1'b1}})) ? '1 : acc_prod[VALUE_BITS-1:0];

  always_comb begin
    ident_kind = K_IDENT;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (kw_prefix == KW_BITS'(KW_TEXT[k]) && tok_len == POS_BITS'(KW_LEN[k])) begin
        ident_kind = KIND_BITS'(k + 1);
      end
    end
  end

  always_comb begin
    mode_next          = mode;
    pending_char_next  = pending_char;
    line_count_next    = line_count;
    column_count_next  = column_count;
    byte_position_next = byte_position;
    tok_pos_next       = tok_pos;
    tok_line_next      = tok_line;
    tok_col_next       = tok_col;
    tok_len_next       = tok_len;
    value_acc_next     = value_acc;
    kw_prefix_next     = kw_prefix;
    p_valid            = 1'b0;
    n_valid            = 1'b0;
    fresh              = 1'b0;

    p_tok.pos   = tok_pos;
    p_tok.line  = tok_line;
    p_tok.col   = tok_col;
    p_tok.len   = tok_len;
    p_tok.value = '0;
    p_tok.last  = 1'b0;
    unique case (mode)
      M_OP:    p_tok.kind = pend_single;
      M_IDENT: p_tok.kind = ident_kind;
      M_INT: begin
        p_tok.kind  = K_INT;
        p_tok.value = value_acc;
      end
      M_DEC: begin
        p_tok.kind  = K_DEC;
        p_tok.value = value_acc;
      end
      default: p_tok.kind = K_END;
    endcase

    n_tok.kind  = K_END;
    n_tok.pos   = byte_position;
    n_tok.line  = line_count;
    n_tok.col   = cur_col;
    n_tok.len   = POS_BITS'(1);
    n_tok.value = '0;
    n_tok.last  = 1'b1;

    if (ch == CH_NUL) begin
      p_valid            = (mode == M_OP || mode == M_IDENT || mode == M_INT || mode == M_DEC);
      n_valid            = 1'b1;
      n_tok.len          = '0;
      mode_next          = M_IDLE;
      pending_char_next  = '0;
      line_count_next    = POS_BITS'(1);
      column_count_next  = '0;
      byte_position_next = '0;
      tok_pos_next       = '0;
      tok_line_next      = POS_BITS'(1);
      tok_col_next       = '0;
      tok_len_next       = '0;
      value_acc_next     = '0;
      kw_prefix_next     = '0;
    end else begin
      unique case (mode)
        M_HALT: fresh = 1'b0;
        M_COMMENT: begin
          if (ch == CH_NL) begin
            mode_next = M_IDLE;
            fresh     = 1'b1;
          end
        end
        M_OP: begin
          if (pending_char == "/" && ch == "/") begin
            mode_next = M_COMMENT;
          end else if (ch == op_second(pending_char) && pend_single != K_ERR) begin
            p_valid    = 1'b1;
            p_tok.kind = pend_single - KIND_BITS'(1);
            p_tok.len  = POS_BITS'(2);
            mode_next  = M_IDLE;
          end else begin
            p_valid   = 1'b1;
            mode_next = M_IDLE;
            fresh     = 1'b1;
          end
        end
        M_IDENT: begin
          if ((ch >= "A" && ch <= "Z") || (ch >= "a" && ch <= "z") ||
              (ch >= "0" && ch <= "9") || ch == "_") begin
            for (int b = 0; b < KEYWORD_BYTES; b++) begin
              if (tok_len == POS_BITS'(b)) begin
                kw_prefix_next[8*b +: 8] = ch;
              end
            end
            tok_len_next = tok_len_inc;
          end else begin
            p_valid   = 1'b1;
            mode_next = M_IDLE;
            fresh     = 1'b1;
          end
        end
        M_INT: begin
          if (ch >= "0" && ch <= "9") begin
            value_acc_next = acc_step;
            tok_len_next   = tok_len_inc;
          end else if (ch == ".") begin
            mode_next    = M_DEC;
            tok_len_next = tok_len_inc;
          end else begin
            p_valid   = 1'b1;
            mode_next = M_IDLE;
            fresh     = 1'b1;
          end
        end
        M_DEC: begin
          if (ch >= "0" && ch <= "9") begin
            tok_len_next = tok_len_inc;
          end else begin
            p_valid   = 1'b1;
            mode_next = M_IDLE;
            fresh     = 1'b1;
          end
        end
        default: begin
          mode_next = M_IDLE;
          fresh     = 1'b1;
        end
      endcase

      if (fresh) begin
        unique case (ch) inside
          "+", "-", "*", "/", "|", ">", "<", "=", "!", "&": begin
            mode_next         = M_OP;
            pending_char_next = ch;
            tok_pos_next      = byte_position;
            tok_line_next     = line_count;
            tok_col_next      = cur_col;
            tok_len_next      = POS_BITS'(1);
          end
          "%": begin
            n_valid    = 1'b1;
            n_tok.kind = K_MOD_ASSIGN;
          end
          "(": begin
            n_valid    = 1'b1;
            n_tok.kind = K_LPAREN;
          end
          ")": begin
            n_valid    = 1'b1;
            n_tok.kind = K_RPAREN;
          end
          "[": begin
            n_valid    = 1'b1;
            n_tok.kind = K_LBRACKET;
          end
          "]": begin
            n_valid    = 1'b1;
            n_tok.kind = K_RBRACKET;
          end
          "{": begin
            n_valid    = 1'b1;
            n_tok.kind = K_LBRACE;
          end
          "}": begin
            n_valid    = 1'b1;
            n_tok.kind = K_RBRACE;
          end
          "~": begin
            n_valid    = 1'b1;
            n_tok.kind = K_BNOT;
          end
          ";": begin
            n_valid    = 1'b1;
            n_tok.kind = K_SEMI;
          end
          ",": begin
            n_valid    = 1'b1;
            n_tok.kind = K_COMMA;
          end
          CH_SPACE, CH_TAB, CH_NL: begin
          end
          ["A":"Z"], ["a":"z"]: begin
            mode_next      = M_IDENT;
            tok_pos_next   = byte_position;
            tok_line_next  = line_count;
            tok_col_next   = cur_col;
            tok_len_next   = POS_BITS'(1);
            kw_prefix_next = KW_BITS'(ch);
          end
          ["0":"9"]: begin
            mode_next      = M_INT;
            tok_pos_next   = byte_position;
            tok_line_next  = line_count;
            tok_col_next   = cur_col;
            tok_len_next   = POS_BITS'(1);
            value_acc_next = VALUE_BITS'(ch[3:0]);
          end
          default: begin
            n_valid    = 1'b1;
            n_tok.kind = K_ERR;
            mode_next  = M_HALT;
          end
        endcase
      end

      byte_position_next = (byte_position == '1) ? byte_position
                                                  : byte_position + POS_BITS'(1);
      if (ch == CH_NL) begin
        line_count_next   = (line_count == '1) ? line_count : line_count + POS_BITS'(1);
        column_count_next = '0;
      end else begin
        column_count_next = cur_col;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= M_IDLE;
      pending_char  <= '0;
      line_count    <= POS_BITS'(1);
      column_count  <= '0;
      byte_position <= '0;
      tok_pos       <= '0;
      tok_line      <= POS_BITS'(1);
      tok_col       <= '0;
      tok_len       <= '0;
      value_acc     <= '0;
      kw_prefix     <= '0;
    end else if (accept) begin
      mode          <= mode_next;
      pending_char  <= pending_char_next;
      line_count    <= line_count_next;
      column_count  <= column_count_next;
      byte_position <= byte_position_next;
      tok_pos       <= tok_pos_next;
      tok_line      <= tok_line_next;
      tok_col       <= tok_col_next;
      tok_len       <= tok_len_next;
      value_acc     <= value_acc_next;
      kw_prefix     <= kw_prefix_next;
    end
  end

  always_comb begin
    r0      = p_valid ? p_tok : n_tok;
    r0.last = !(p_valid && n_valid);
    r1      = n_tok;
    n_push  = accept ? ({1'b0, p_valid} + {1'b0, n_valid}) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      fifo[wr_ptr] <= r0;
    end
    if (n_push == 2'd2) begin
      fifo[wr_ptr + FIFO_AW'(1)] <= r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_AW'(n_push);
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      count <= count + CNT_BITS'(n_push) - CNT_BITS'(pop);
    end
  end

  assign in_stall    = count > CNT_BITS'(FIFO_DEPTH - 2);
  assign out_valid   = count != '0;
  assign kind        = fifo[rd_ptr].kind;
  assign start_pos   = fifo[rd_ptr].pos;
  assign line        = fifo[rd_ptr].line;
  assign col         = fifo[rd_ptr].col;
  assign length      = fifo[rd_ptr].len;
  assign value       = fifo[rd_ptr].value;
  assign last_of_run = fifo[rd_ptr].last;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_BITS'(FIFO_DEPTH))
    else $error("token queue count exceeds its depth");

  a_end_restarts: assert property (@(posedge clk) disable iff (rst)
    accept && ch == CH_NUL |=> mode == M_IDLE && byte_position == '0 &&
                               line_count == POS_BITS'(1))
    else $error("scanner state not restarted after end of source");

  a_open_token_len: assert property (@(posedge clk) disable iff (rst)
    (mode == M_OP || mode == M_IDENT || mode == M_INT || mode == M_DEC) |-> tok_len != '0)
    else $error("open token has zero length");

  a_halt_silent: assert property (@(posedge clk) disable iff (rst)
    accept && mode == M_HALT && ch != CH_NUL |=> count == $past(count) - CNT_BITS'($past(pop)))
    else $error("halted scanner produced a token");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for source_text_tokenizer: random and directed source text in, tokens
// checked field by field against a scanner model kept here. Depends on sttok_pkg and the RTL.
module testbench;
  import sttok_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned RANDOM_BYTES_PER_PHASE = 330;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;
  localparam longint unsigned VALUE_MAX = 64'h7FFF_FFFF;

  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_OP, SCAN_IDENT, SCAN_INT, SCAN_DEC, SCAN_COMMENT, SCAN_HALT
  } scan_mode_e;

  typedef struct packed {
    logic [KIND_BITS-1:0] kind;
    logic [15:0]          start_pos;
    logic [15:0]          line;
    logic [15:0]          col;
    logic [15:0]          length;
    logic [30:0]          value;
    logic                 last_of_run;
  } token_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           ch = 8'h00;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [KIND_BITS-1:0] kind;
  logic [15:0]          start_pos;
  logic [15:0]          line;
  logic [15:0]          col;
  logic [15:0]          length;
  logic [30:0]          value;
  logic                 last_of_run;

  source_text_tokenizer dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .ch(ch),
    .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .start_pos(start_pos), .line(line), .col(col),
    .length(length), .value(value), .last_of_run(last_of_run)
  );

  scan_mode_e  scan_mode = SCAN_IDLE;
  logic [7:0]  op_char = 8'h00;
  logic [15:0] line_no = 16'd1;
  logic [15:0] col_no = 16'd0;
  logic [15:0] byte_pos = 16'd0;
  logic [15:0] tok_pos = 16'd0;
  logic [15:0] tok_line = 16'd1;
  logic [15:0] tok_col = 16'd0;
  logic [15:0] tok_len = 16'd0;
  logic [30:0] num_value = '0;
  logic [47:0] word_head = '0;

  token_t      expected_tokens[$];
  token_t      byte_tokens[$];
  logic [7:0]  pending_bytes[$];

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned pushed_bytes = 0;
  int unsigned accepted_bytes = 0;
  int unsigned sources_scanned = 0;
  int unsigned tokens_checked = 0;
  int unsigned failures = 0;
  int unsigned quiet_cycles = 0;
  logic [40:0] seen_kinds = '0;

  int unsigned idle_plan[5] = '{0, 88, 0, 36, 0};
  int unsigned stall_plan[5] = '{0, 0, 88, 36, 0};
  string keyword_words[6] = '{"if", "else", "while", "for", "return", "func"};
  string operator_texts[30] = '{"+=", "+", "-=", "-", "*=", "*", "/=", "/", "%", "(", ")",
    "[", "]", "{", "}", "||", "|", ">=", ">", "<=", "<", "==", "=", "!=", "!", "~", "&&", "&",
    ";", ","};

  function automatic logic [15:0] bump(input logic [15:0] v);
    return (v == COUNT_MAX) ? v : v + 16'd1;
  endfunction

  function automatic bit is_letter(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [KIND_BITS-1:0] operator_kind(input logic [7:0] c);
    case (c)
      "+": return K_ADD;
      "-": return K_SUB;
      "*": return K_MUL;
      "/": return K_DIV;
      "|": return K_BOR;
      ">": return K_GT;
      "<": return K_LT;
      "=": return K_ASSIGN;
      "!": return K_NOT;
      "&": return K_BAND;
      default: return K_ERR;
    endcase
  endfunction

  function automatic logic [7:0] operator_partner(input logic [7:0] c);
    return (c == "|" || c == "&") ? c : "=";
  endfunction

  // The word head holds the first six bytes of a word, most recent byte lowest.
  function logic [KIND_BITS-1:0] word_kind();
    if (tok_len > 16'd6) return K_IDENT;
    case (word_head)
      {32'd0, "if"}:    return K_IF;
      {16'd0, "else"}:  return K_ELSE;
      {8'd0, "while"}:  return K_WHILE;
      {24'd0, "for"}:   return K_FOR;
      "return":         return K_RETURN;
      {16'd0, "func"}:  return K_FUNC;
      default:          return K_IDENT;
    endcase
  endfunction

  function void clear_scanner();
    scan_mode = SCAN_IDLE;
    op_char = 8'h00;
    line_no = 16'd1;
    col_no = 16'd0;
    byte_pos = 16'd0;
    tok_pos = 16'd0;
    tok_line = 16'd1;
    tok_col = 16'd0;
    tok_len = 16'd0;
    num_value = '0;
    word_head = '0;
  endfunction

  function void emit_token(input logic [KIND_BITS-1:0] k, input logic [15:0] pos,
                           input logic [15:0] ln, input logic [15:0] cl,
                           input logic [15:0] len, input logic [30:0] val);
    token_t t;
    t.kind = k;
    t.start_pos = pos;
    t.line = ln;
    t.col = cl;
    t.length = len;
    t.value = val;
    t.last_of_run = 1'b0;
    byte_tokens.push_back(t);
  endfunction

  function void flush_token();
    logic [KIND_BITS-1:0] k;
    logic [30:0] v;
    v = '0;
    case (scan_mode)
      SCAN_OP:    k = operator_kind(op_char);
      SCAN_IDENT: k = word_kind();
      SCAN_INT: begin
        k = K_INT;
        v = num_value;
      end
      SCAN_DEC: begin
        k = K_DEC;
        v = num_value;
      end
      default: return;
    endcase
    emit_token(k, tok_pos, tok_line, tok_col, tok_len, v);
    scan_mode = SCAN_IDLE;
  endfunction

  function void open_token(input scan_mode_e m, input logic [15:0] pos,
                           input logic [15:0] column);
    scan_mode = m;
    tok_pos = pos;
    tok_line = line_no;
    tok_col = column;
    tok_len = 16'd1;
  endfunction

  function void start_token(input logic [7:0] c, input logic [15:0] pos,
                            input logic [15:0] column);
    logic [KIND_BITS-1:0] k;
    k = K_ERR;
    case (c)
      "+", "-", "*", "/", "|", ">", "<", "=", "!", "&": begin
        open_token(SCAN_OP, pos, column);
        op_char = c;
      end
      "%": k = K_MOD_ASSIGN;
      "(": k = K_LPAREN;
      ")": k = K_RPAREN;
      "[": k = K_LBRACKET;
      "]": k = K_RBRACKET;
      "{": k = K_LBRACE;
      "}": k = K_RBRACE;
      "~": k = K_BNOT;
      ";": k = K_SEMI;
      ",": k = K_COMMA;
      CH_SPACE, CH_TAB, CH_NL: ;
      default: begin
        if (is_letter(c)) begin
          open_token(SCAN_IDENT, pos, column);
          word_head = {40'd0, c};
        end else if (is_digit(c)) begin
          open_token(SCAN_INT, pos, column);
          num_value = 31'(c - "0");
        end else begin
          emit_token(K_ERR, pos, line_no, column, 16'd1, '0);
          scan_mode = SCAN_HALT;
        end
      end
    endcase
    if (k != K_ERR) emit_token(k, pos, line_no, column, 16'd1, '0);
  endfunction

  // Works out the tokens that one accepted request gives and queues them.
  function void scan_byte(input logic [7:0] c);
    logic [15:0] pos;
    logic [15:0] column;
    bit fresh;
    longint unsigned wide;
    longint unsigned digit;
    pos = byte_pos;
    column = bump(col_no);
    fresh = 1'b1;
    byte_tokens = {};
    if (c == CH_NUL) begin
      flush_token();
      emit_token(K_END, pos, line_no, column, 16'd0, '0);
      clear_scanner();
      sources_scanned++;
    end else begin
      case (scan_mode)
        SCAN_HALT: fresh = 1'b0;
        SCAN_COMMENT: begin
          if (c == CH_NL) scan_mode = SCAN_IDLE;
          else fresh = 1'b0;
        end
        SCAN_OP: begin
          if (op_char == "/" && c == "/") begin
            scan_mode = SCAN_COMMENT;
            fresh = 1'b0;
          end else if (c == operator_partner(op_char)) begin
            emit_token(operator_kind(op_char) - 6'd1, tok_pos, tok_line, tok_col, 16'd2, '0);
            scan_mode = SCAN_IDLE;
            fresh = 1'b0;
          end else begin
            flush_token();
          end
        end
        SCAN_IDENT: begin
          if (is_letter(c) || is_digit(c) || c == "_") begin
            if (tok_len < 16'd6) word_head = {word_head[39:0], c};
            tok_len = bump(tok_len);
            fresh = 1'b0;
          end else begin
            flush_token();
          end
        end
        SCAN_INT: begin
          if (is_digit(c)) begin
            wide = num_value;
            digit = c - "0";
            if (wide > (VALUE_MAX - digit) / 10) num_value = 31'(VALUE_MAX);
            else num_value = 31'(wide * 10 + digit);
            tok_len = bump(tok_len);
            fresh = 1'b0;
          end else if (c == ".") begin
            scan_mode = SCAN_DEC;
            tok_len = bump(tok_len);
            fresh = 1'b0;
          end else begin
            flush_token();
          end
        end
        SCAN_DEC: begin
          if (is_digit(c)) begin
            tok_len = bump(tok_len);
            fresh = 1'b0;
          end else begin
            flush_token();
          end
        end
        default: ;
      endcase
      if (fresh) start_token(c, pos, column);
      byte_pos = bump(byte_pos);
      if (c == CH_NL) begin
        line_no = bump(line_no);
        col_no = 16'd0;
      end else begin
        col_no = column;
      end
    end
    if (byte_tokens.size() > 0) byte_tokens[$].last_of_run = 1'b1;
    foreach (byte_tokens[i]) expected_tokens.push_back(byte_tokens[i]);
  endfunction

  function void push_byte(input logic [7:0] b);
    pending_bytes.push_back(b);
    pushed_bytes++;
  endfunction

  function void push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(8'(s[i]));
  endfunction

  function logic [7:0] random_word_char();
    int unsigned r;
    r = $urandom_range(62);
    if (r < 26) return 8'("a") + 8'(r);
    if (r < 52) return 8'("A") + 8'(r - 26);
    if (r < 62) return 8'("0") + 8'(r - 52);
    return "_";
  endfunction

  function logic [7:0] random_blank();
    case ($urandom_range(2))
      0: return CH_SPACE;
      1: return CH_TAB;
      default: return CH_NL;
    endcase
  endfunction

  // One source: a run of mostly well-formed tokens with random content, then byte 0.
  function void push_random_source();
    int unsigned pick;
    int unsigned reach;
    int unsigned b;
    repeat ($urandom_range(1, 14)) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        push_text(keyword_words[$urandom_range(5)]);
        if ($urandom_range(3) == 0) push_byte(random_word_char());
      end else if (pick < 28) begin
        push_byte(($urandom_range(1) == 1) ? 8'("a") + 8'($urandom_range(25))
                                           : 8'("A") + 8'($urandom_range(25)));
        reach = ($urandom_range(9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
        repeat (reach) push_byte(random_word_char());
      end else if (pick < 41) begin
        reach = ($urandom_range(4) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 4);
        repeat (reach) push_byte(8'("0") + 8'($urandom_range(9)));
      end else if (pick < 49) begin
        repeat ($urandom_range(1, 3)) push_byte(8'("0") + 8'($urandom_range(9)));
        push_text(".");
        repeat ($urandom_range(0, 3)) push_byte(8'("0") + 8'($urandom_range(9)));
        if ($urandom_range(7) == 0) push_text(".");
      end else if (pick < 73) begin
        push_text(operator_texts[$urandom_range(29)]);
      end else if (pick < 80) begin
        push_text("//");
        repeat ($urandom_range(0, 8)) begin
          b = $urandom_range(1, 255);
          push_byte((b == 32'(CH_NL)) ? 8'h0B : 8'(b));
        end
        push_byte(CH_NL);
      end else if (pick < 97) begin
        push_byte(random_blank());
      end else begin
        push_byte(8'($urandom_range(1, 255)));
      end
      if ($urandom_range(1) == 1) push_byte(random_blank());
    end
    push_byte(CH_NUL);
  endfunction

  function void check_field(input string name, input longint unsigned want,
                            input longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        scan_byte(ch);
        accepted_bytes++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          ch <= pending_bytes.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : receive
    token_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_tokens.size() == 0) begin
          $error("token kind %0d at %0d with nothing expected", kind, start_pos);
          failures++;
        end else begin
          want = expected_tokens.pop_front();
          check_field("kind", want.kind, kind);
          check_field("start_pos", want.start_pos, start_pos);
          check_field("line", want.line, line);
          check_field("col", want.col, col);
          check_field("length", want.length, length);
          check_field("value", want.value, value);
          check_field("last_of_run", want.last_of_run, last_of_run);
          tokens_checked++;
          if (kind <= K_ERR) seen_kinds[kind] = 1'b1;
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("tb: failure");
    $finish;
  end

  initial begin : run
    int unsigned target;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    push_byte(CH_NUL);
    push_text("_");
    push_byte(8'hFF);
    push_byte(CH_NUL);
    push_text("1.5.");
    push_byte(8'h80);
    push_byte(CH_NUL);
    push_text("9.");
    push_byte(CH_NUL);
    push_text("4294967296");
    push_byte(CH_NUL);
    while (pending_bytes.size() > 0) @(posedge clk);

    for (int p = 0; p < 5; p++) begin
      send_idle_pct = idle_plan[p];
      stall_pct = stall_plan[p];
      target = pushed_bytes + RANDOM_BYTES_PER_PHASE;
      while (pushed_bytes < target) push_random_source();
      while (pending_bytes.size() > 0) @(posedge clk);
    end

    while (in_valid) @(posedge clk);
    while (expected_tokens.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb: %0d source bytes in %0d sources, %0d tokens checked, %0d mismatches",
             accepted_bytes, sources_scanned, tokens_checked, failures);
    $display("tb: %0d of 41 token kinds seen, value overflow and error halts, idle/stall mixes",
             $countones(seen_kinds));
    if (failures == 0 && expected_tokens.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/sttok_pkg.sv
hw/rtl/source_text_tokenizer.sv
tb/testbench.sv
